### hw/rtl/nds_pkg.sv
// shared types, constants and lookup tables of the noise drone sequencer
`default_nettype none

package nds_pkg;

	// configuration of the pattern tables
	localparam int PITCH_STEPS = 23;
	localparam int SURF_LENGTH = 6;

	// widths of the stored state
	localparam int PITCH_W = 5;
	localparam int VOL_W   = 4;
	localparam int SIDX_W  = 3;
	localparam int FRAC_W  = 4;

	localparam logic [7:0]         PITCH_MAX_IN = 8'(PITCH_STEPS - 1);
	localparam logic [PITCH_W-1:0] PITCH_LAST   = PITCH_W'(PITCH_STEPS - 1);
	localparam logic [7:0]         VOL_MAX_IN   = 8'd15;
	localparam logic [VOL_W-1:0]   VOL_LAST     = 4'd15;
	localparam logic [SIDX_W:0]    SURF_WRAP    = (SIDX_W + 1)'(SURF_LENGTH);

	localparam logic [7:0] BUZZ_OR  = 8'h08;
	localparam int         FRAC_ADD = 16;
	localparam int         FRAC_MOD = 15;
	localparam logic [FRAC_W:0]   FRAC_STEP  = (FRAC_W + 1)'(FRAC_ADD - FRAC_MOD);
	localparam logic [FRAC_W:0]   FRAC_LIMIT = (FRAC_W + 1)'(FRAC_MOD);
	localparam logic [FRAC_W-1:0] FRAC_SUB   = FRAC_W'(FRAC_MOD);

	// command codes
	typedef enum logic [2:0] {
		ACT_TICK   = 3'd0,
		ACT_DRONE  = 3'd1,
		ACT_TARGET = 3'd2,
		ACT_SURF   = 3'd3,
		ACT_STOP   = 3'd4
	} action_t;

	// write kinds toward the sound channel
	typedef enum logic [1:0] {
		WK_FULL    = 2'd0,
		WK_POLY    = 2'd1,
		WK_SILENCE = 2'd2
	} kind_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SURF2
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic commit;
		logic phase2;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic two_step;
		logic emit;
		logic out_free;
	} sts_t;

	// poly register value per pitch step, the last entry also covers indices past the end
	function automatic logic [7:0] pitch_rom(input logic [PITCH_W-1:0] idx);
		logic [7:0] val;
		case (idx)
			5'd0:    val = 8'h85;
			5'd1:    val = 8'h84;
			5'd2:    val = 8'h77;
			5'd3:    val = 8'h76;
			5'd4:    val = 8'h75;
			5'd5:    val = 8'h74;
			5'd6:    val = 8'h67;
			5'd7:    val = 8'h66;
			5'd8:    val = 8'h65;
			5'd9:    val = 8'h64;
			5'd10:   val = 8'h57;
			5'd11:   val = 8'h56;
			5'd12:   val = 8'h55;
			5'd13:   val = 8'h54;
			5'd14:   val = 8'h47;
			5'd15:   val = 8'h46;
			5'd16:   val = 8'h45;
			5'd17:   val = 8'h44;
			5'd18:   val = 8'h37;
			5'd19:   val = 8'h36;
			5'd20:   val = 8'h35;
			5'd21:   val = 8'h34;
			default: val = 8'h27;
		endcase
		return val;
	endfunction

	// surf table row, the six-row table repeats
	function automatic logic [SIDX_W-1:0] surf_row(input logic [SIDX_W-1:0] idx);
		logic [SIDX_W-1:0] row;
		row = (idx >= 3'd6) ? idx - 3'd6 : idx;
		return row;
	endfunction

	function automatic logic [7:0] surf_env(input logic [SIDX_W-1:0] idx);
		logic [7:0] val;
		case (surf_row(idx))
			3'd0, 3'd3: val = 8'h1F;
			3'd1, 3'd4: val = 8'h97;
			default:    val = 8'h20;
		endcase
		return val;
	endfunction

	function automatic logic [7:0] surf_poly(input logic [SIDX_W-1:0] idx);
		logic [7:0] val;
		case (surf_row(idx))
			3'd2, 3'd5: val = 8'h34;
			default:    val = 8'h27;
		endcase
		return val;
	endfunction

	function automatic logic [7:0] surf_dur(input logic [SIDX_W-1:0] idx);
		logic [7:0] val;
		case (surf_row(idx))
			3'd2:    val = 8'd112;
			3'd5:    val = 8'd168;
			default: val = 8'd42;
		endcase
		return val;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/nds_cmd_if.sv
// command channel: valid/ready handshake with the command payload
`default_nettype none

interface nds_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] pitch;
	logic [7:0] volume;
	logic       buzz;
	logic [7:0] slide_period;
	logic       sfx_owns;

	modport source (
		output valid, action, pitch, volume, buzz, slide_period, sfx_owns,
		input  ready
	);
	modport sink (
		input  valid, action, pitch, volume, buzz, slide_period, sfx_owns,
		output ready
	);
endinterface

`default_nettype wire

### hw/rtl/nds_wr_if.sv
// register write channel: valid/ready handshake with the channel write payload
`default_nettype none

interface nds_wr_if;
	logic       valid;
	logic       ready;
	logic [1:0] write_kind;
	logic [7:0] envelope;
	logic [7:0] poly;

	modport source (
		output valid, write_kind, envelope, poly,
		input  ready
	);
	modport sink (
		input  valid, write_kind, envelope, poly,
		output ready
	);
endinterface

`default_nettype wire

### hw/rtl/nds_datapath.sv
// datapath: command register, drone and surf state, next state logic, write register
`default_nettype none

module nds_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire nds_pkg::ctl_t       ctl,
	output nds_pkg::sts_t            sts,
	input  wire logic [2:0]          action,
	input  wire logic [7:0]          pitch,
	input  wire logic [7:0]          volume,
	input  wire logic                buzz,
	input  wire logic [7:0]          slide_period,
	input  wire logic                sfx_owns,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [1:0]               out_kind,
	output logic [7:0]               out_env,
	output logic [7:0]               out_poly
);

	// captured command
	logic [2:0]                  act_q;
	logic [nds_pkg::PITCH_W-1:0] pit_q;
	logic [nds_pkg::VOL_W-1:0]   vol_q;
	logic                        buzz_q;
	logic [7:0]                  period_q;
	logic                        owned_q;

	// channel state
	logic                        drone_on_q, surf_on_q, buzz_bit_q, stolen_q, adv_q;
	logic [nds_pkg::VOL_W-1:0]   vol_now_q, vol_goal_q;
	logic [nds_pkg::PITCH_W-1:0] pitch_now_q, pitch_goal_q;
	logic [7:0]                  slide_len_q, slide_cnt_q;
	logic [nds_pkg::SIDX_W-1:0]  sidx_q;
	logic [7:0]                  sleft_q;
	logic [nds_pkg::FRAC_W-1:0]  sfrac_q;

	logic                        drone_on_d, surf_on_d, buzz_bit_d, stolen_d, adv_d;
	logic [nds_pkg::VOL_W-1:0]   vol_now_d, vol_goal_d;
	logic [nds_pkg::PITCH_W-1:0] pitch_now_d, pitch_goal_d;
	logic [7:0]                  slide_len_d, slide_cnt_d;
	logic [nds_pkg::SIDX_W-1:0]  sidx_d;
	logic [7:0]                  sleft_d;
	logic [nds_pkg::FRAC_W-1:0]  sfrac_d;

	// result of this step
	logic           emit, two_step, res_surf;
	nds_pkg::kind_t res_kind;
	logic [7:0]     res_env, res_poly, drone_poly;

	// output register
	logic           out_valid_q;
	nds_pkg::kind_t out_kind_q;
	logic [7:0]     out_env_q, out_poly_q;

	// one step of the surf duration counter
	logic [7:0]                  left_dec, left_adv, cnt_inc;
	logic                        adv, adv_all, differ, final_surf;
	logic [nds_pkg::SIDX_W:0]    idx_p1;
	logic [nds_pkg::SIDX_W-1:0]  idx_adv;
	logic [nds_pkg::FRAC_W:0]    frac1;

	assign left_dec = (sleft_q != 8'd0) ? sleft_q - 8'd1 : sleft_q;
	assign adv      = (left_dec == 8'd0);
	assign idx_p1   = {1'b0, sidx_q} + 4'd1;
	assign idx_adv  = !adv ? sidx_q :
		(idx_p1 >= nds_pkg::SURF_WRAP) ? '0 : idx_p1[nds_pkg::SIDX_W-1:0];
	assign left_adv = adv ? nds_pkg::surf_dur(idx_adv) : left_dec;
	assign frac1    = {1'b0, sfrac_q} + nds_pkg::FRAC_STEP;
	assign differ   = (pitch_now_q != pitch_goal_q) || (vol_now_q != vol_goal_q);
	assign cnt_inc  = slide_cnt_q + 8'd1;

	// command capture with clamping
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			act_q    <= action;
			pit_q    <= (pitch > nds_pkg::PITCH_MAX_IN) ? nds_pkg::PITCH_LAST
				: pitch[nds_pkg::PITCH_W-1:0];
			vol_q    <= (volume > nds_pkg::VOL_MAX_IN) ? nds_pkg::VOL_LAST
				: volume[nds_pkg::VOL_W-1:0];
			buzz_q   <= buzz;
			period_q <= slide_period;
			owned_q  <= sfx_owns;
		end
	end

	// next state and result for the captured command
	always_comb begin
		drone_on_d   = drone_on_q;
		surf_on_d    = surf_on_q;
		buzz_bit_d   = buzz_bit_q;
		stolen_d     = stolen_q;
		adv_d        = adv_q;
		vol_now_d    = vol_now_q;
		vol_goal_d   = vol_goal_q;
		pitch_now_d  = pitch_now_q;
		pitch_goal_d = pitch_goal_q;
		slide_len_d  = slide_len_q;
		slide_cnt_d  = slide_cnt_q;
		sidx_d       = sidx_q;
		sleft_d      = sleft_q;
		sfrac_d      = sfrac_q;
		emit         = 1'b0;
		two_step     = 1'b0;
		res_surf     = 1'b0;
		res_kind     = nds_pkg::WK_FULL;
		adv_all      = adv;
		final_surf   = 1'b0;
		case (act_q)
			nds_pkg::ACT_TICK: begin
				if (surf_on_q) begin
					// surf: one or two counter steps per frame
					sleft_d  = left_adv;
					sidx_d   = idx_adv;
					res_surf = 1'b1;
					if (ctl.phase2) begin
						sfrac_d    = sfrac_q - nds_pkg::FRAC_SUB;
						adv_all    = adv_q | adv;
						final_surf = 1'b1;
					end else begin
						sfrac_d = frac1[nds_pkg::FRAC_W-1:0];
						if (frac1 >= nds_pkg::FRAC_LIMIT) begin
							two_step = 1'b1;
							adv_d    = adv;
						end else begin
							final_surf = 1'b1;
						end
					end
					if (final_surf) begin
						stolen_d = owned_q;
						emit     = !owned_q && (adv_all || stolen_q);
					end
				end else if (drone_on_q) begin
					if (owned_q) begin
						stolen_d = 1'b1;
					end else begin
						// slide toward the goals
						if (differ) begin
							if (slide_len_q == 8'd0) begin
								pitch_now_d = pitch_goal_q;
								vol_now_d   = vol_goal_q;
								emit        = 1'b1;
							end else begin
								slide_cnt_d = cnt_inc;
								if (cnt_inc >= slide_len_q) begin
									slide_cnt_d = 8'd0;
									if (pitch_now_q < pitch_goal_q) begin
										pitch_now_d = pitch_now_q + 5'd1;
										emit        = 1'b1;
										res_kind    = nds_pkg::WK_POLY;
									end else if (pitch_now_q > pitch_goal_q) begin
										pitch_now_d = pitch_now_q - 5'd1;
										emit        = 1'b1;
										res_kind    = nds_pkg::WK_POLY;
									end
									if (vol_now_q < vol_goal_q) begin
										vol_now_d = vol_now_q + 4'd1;
										emit      = 1'b1;
										res_kind  = nds_pkg::WK_FULL;
									end else if (vol_now_q > vol_goal_q) begin
										vol_now_d = vol_now_q - 4'd1;
										emit      = 1'b1;
										res_kind  = nds_pkg::WK_FULL;
									end
								end
							end
						end
						if (stolen_q) begin
							stolen_d = 1'b0;
							emit     = 1'b1;
							res_kind = nds_pkg::WK_FULL;
						end
					end
				end
			end
			nds_pkg::ACT_DRONE: begin
				surf_on_d    = 1'b0;
				pitch_now_d  = pit_q;
				pitch_goal_d = pit_q;
				vol_now_d    = vol_q;
				vol_goal_d   = vol_q;
				buzz_bit_d   = buzz_q;
				slide_len_d  = 8'd0;
				slide_cnt_d  = 8'd0;
				drone_on_d   = 1'b1;
				stolen_d     = owned_q;
				emit         = !owned_q;
			end
			nds_pkg::ACT_TARGET: begin
				slide_len_d  = period_q;
				slide_cnt_d  = 8'd0;
				pitch_goal_d = pit_q;
				vol_goal_d   = vol_q;
				if (period_q == 8'd0) begin
					pitch_now_d = pit_q;
					vol_now_d   = vol_q;
				end
				emit = drone_on_q && !owned_q && !stolen_q && (period_q == 8'd0);
			end
			nds_pkg::ACT_SURF: begin
				drone_on_d = 1'b0;
				sidx_d     = '0;
				sleft_d    = nds_pkg::surf_dur('0);
				sfrac_d    = '0;
				surf_on_d  = 1'b1;
				stolen_d   = owned_q;
				emit       = !owned_q;
				res_surf   = 1'b1;
			end
			nds_pkg::ACT_STOP: begin
				drone_on_d = 1'b0;
				surf_on_d  = 1'b0;
				vol_now_d  = '0;
				vol_goal_d = '0;
				emit       = (drone_on_q || surf_on_q) && !owned_q;
				res_kind   = nds_pkg::WK_SILENCE;
			end
			default: begin
			end
		endcase
	end

	// write values from the updated state
	assign drone_poly = nds_pkg::pitch_rom(pitch_now_d) | (buzz_bit_d ? nds_pkg::BUZZ_OR : 8'h00);

	always_comb begin
		res_env  = 8'h00;
		res_poly = 8'h00;
		case (res_kind)
			nds_pkg::WK_FULL: begin
				if (res_surf) begin
					res_env  = nds_pkg::surf_env(sidx_d);
					res_poly = nds_pkg::surf_poly(sidx_d);
				end else begin
					res_env  = {vol_now_d, 4'h0};
					res_poly = drone_poly;
				end
			end
			nds_pkg::WK_POLY: res_poly = drone_poly;
			default: begin
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drone_on_q   <= 1'b0;
			surf_on_q    <= 1'b0;
			buzz_bit_q   <= 1'b0;
			stolen_q     <= 1'b0;
			adv_q        <= 1'b0;
			vol_now_q    <= '0;
			vol_goal_q   <= '0;
			pitch_now_q  <= '0;
			pitch_goal_q <= '0;
			slide_len_q  <= '0;
			slide_cnt_q  <= '0;
			sidx_q       <= '0;
			sleft_q      <= '0;
			sfrac_q      <= '0;
		end else if (ctl.commit) begin
			drone_on_q   <= drone_on_d;
			surf_on_q    <= surf_on_d;
			buzz_bit_q   <= buzz_bit_d;
			stolen_q     <= stolen_d;
			adv_q        <= adv_d;
			vol_now_q    <= vol_now_d;
			vol_goal_q   <= vol_goal_d;
			pitch_now_q  <= pitch_now_d;
			pitch_goal_q <= pitch_goal_d;
			slide_len_q  <= slide_len_d;
			slide_cnt_q  <= slide_cnt_d;
			sidx_q       <= sidx_d;
			sleft_q      <= sleft_d;
			sfrac_q      <= sfrac_d;
		end
	end

	// output register, holds a transaction until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.commit && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit && emit) begin
			out_kind_q <= res_kind;
			out_env_q  <= res_env;
			out_poly_q <= res_poly;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_kind     = out_kind_q;
	assign out_env      = out_env_q;
	assign out_poly     = out_poly_q;
	assign sts.two_step = two_step;
	assign sts.emit     = emit;
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

`default_nettype wire

### hw/rtl/nds_ctrl.sv
// controller: sequences command capture, execution and the second surf step
`default_nettype none

module nds_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire nds_pkg::sts_t sts,
	output nds_pkg::ctl_t      ctl
);

	nds_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nds_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		ctl.load   = 1'b0;
		ctl.commit = 1'b0;
		ctl.phase2 = 1'b0;
		in_ready   = 1'b0;
		unique case (state_q)
			nds_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = nds_pkg::ST_EXEC;
				end
			end
			nds_pkg::ST_EXEC: begin
				if (sts.two_step) begin
					ctl.commit = 1'b1;
					state_d    = nds_pkg::ST_SURF2;
				end else if (!sts.emit || sts.out_free) begin
					ctl.commit = 1'b1;
					state_d    = nds_pkg::ST_IDLE;
				end
			end
			nds_pkg::ST_SURF2: begin
				ctl.phase2 = 1'b1;
				if (!sts.emit || sts.out_free) begin
					ctl.commit = 1'b1;
					state_d    = nds_pkg::ST_IDLE;
				end
			end
			default: state_d = nds_pkg::ST_IDLE;
		endcase
	end

`ifndef SYNTH
	// a result is never committed over a write still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.commit && sts.emit) |-> sts.out_free)
		else $error("result committed while output register busy");

	// a double surf step always moves on to the second surf step state
	a_two_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nds_pkg::ST_EXEC && sts.two_step) |=> state_q == nds_pkg::ST_SURF2)
		else $error("second surf step skipped");

	// the second step never asks for a third
	a_no_third: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nds_pkg::ST_SURF2) |-> !sts.two_step)
		else $error("surf step requested a third cycle");
`endif

endmodule

`default_nettype wire

### hw/rtl/noise_drone_sequencer_core.sv
// Noise drone sequencer: controller for a noise sound channel.
// Commands (frame tick, start drone, set target, start surf, stop) arrive on
// the cmd channel with the sound-effect ownership flag; each transaction
// causes zero or one register write transaction on the wr channel
// (full write with trigger, poly register only, or silence and trigger).
// Timing: a command is taken in the idle state and then executed in the
// execute state; a new command is not taken until the last one is done. A
// surf frame tick whose fractional accumulator wraps also passes through the
// second surf step state for the second step of the duration counter. The
// write is registered and appears on wr once the last step has committed.
// The write sits in an output register; the next command is still taken
// while it waits, but a command that itself produces a write holds in
// execution until the receiver takes the earlier one.
// Reset (arst_n low) clears all drone and surf state and drops any
// pending write; no writes appear until a command causes one.
`default_nettype none

module noise_drone_sequencer_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	nds_cmd_if.sink     cmd,
	nds_wr_if.source    wr
);

	nds_pkg::ctl_t ctl;
	nds_pkg::sts_t sts;
	logic          in_ready;

	// sequencing of each command
	nds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	// state, next state and write register
	nds_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.action       (cmd.action),
		.pitch        (cmd.pitch),
		.volume       (cmd.volume),
		.buzz         (cmd.buzz),
		.slide_period (cmd.slide_period),
		.sfx_owns     (cmd.sfx_owns),
		.out_valid    (wr.valid),
		.out_ready    (wr.ready),
		.out_kind     (wr.write_kind),
		.out_env      (wr.envelope),
		.out_poly     (wr.poly)
	);

	assign cmd.ready = in_ready;

endmodule

`default_nettype wire
